/* rtl/core/sfa_pkg.sv */
// ----------------------------------------------------------------------------
// Stack frame allocator package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int MAX_FRAMES     = 64;
   localparam int FRAME_IDX_BITS = $clog2(MAX_FRAMES);
   localparam int COUNT_BITS     = FRAME_IDX_BITS + 1;
   localparam int SIZE_BITS      = 21;
   localparam int ADDR_BITS      = 20;
   localparam int HEADER_BYTES   = 8;
   localparam int HDR_EVEN       = ((HEADER_BYTES + 1) / 2) * 2;
   localparam int BASE_OFFSET    = 16;
   localparam int ARENA_RESET    = 1048576;
   localparam int ADDR_MASK      = (2 ** ADDR_BITS) - 1;
   localparam int MEM_BITS       = SIZE_BITS + 1;
   localparam int TAIL_BITS      = SIZE_BITS + 2;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ARENA_FULL = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_NOT_FOUND  = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_SRCH_RD,
      ST_SRCH_CHK,
      ST_POP_RD,
      ST_POP_WR,
      ST_DONE
   } state_type;

   typedef enum logic {
      RD_SEARCH,
      RD_POP
   } rd_sel_type;

   typedef struct packed {
      logic       capture;        // take the request payload
      logic       alloc;          // evaluate allocation, push when it fits
      logic       rd_en;          // read the frame table
      rd_sel_type rd_sel;
      logic       idx_next;       // advance the search index
      logic       mark_unused;    // clear the used bit of the found frame
      logic       pend_ok;        // free found its frame
      logic       pend_not_found; // search ran off the end
      logic       pop_commit;     // drop the top frame
      logic       out_load;       // move the pending result to the output
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic search_end;
      logic match;
      logic pop_stop;
      logic out_free;
   } stat_type;

endpackage

/* rtl/core/sfa_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack frame allocator controller
// Sequences allocate, the frame table search and the pop of unused frames.
// ----------------------------------------------------------------------------
module sfa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfa_pkg::stat_type stat,
   output sfa_pkg::cmd_type  cmd
);

   sfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = sfa_pkg::RD_SEARCH;
      req_ready = 1'b0;
      case (state_ff)
         sfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = sfa_pkg::ST_ALLOC;
            end
         end
         sfa_pkg::ST_ALLOC: begin
            // the captured op decides the path
            if (stat.is_free) begin
               state_in = sfa_pkg::ST_SRCH_RD;
            end else begin
               cmd.alloc = 1'b1;
               state_in  = sfa_pkg::ST_DONE;
            end
         end
         sfa_pkg::ST_SRCH_RD: begin
            if (stat.search_end) begin
               cmd.pend_not_found = 1'b1;
               state_in           = sfa_pkg::ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sfa_pkg::RD_SEARCH;
               state_in   = sfa_pkg::ST_SRCH_CHK;
            end
         end
         sfa_pkg::ST_SRCH_CHK: begin
            if (stat.match) begin
               cmd.mark_unused = 1'b1;
               cmd.pend_ok     = 1'b1;
               state_in        = sfa_pkg::ST_POP_RD;
            end else begin
               cmd.idx_next = 1'b1;
               state_in     = sfa_pkg::ST_SRCH_RD;
            end
         end
         sfa_pkg::ST_POP_RD: begin
            if (stat.pop_stop) begin
               state_in = sfa_pkg::ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = sfa_pkg::RD_POP;
               state_in   = sfa_pkg::ST_POP_WR;
            end
         end
         sfa_pkg::ST_POP_WR: begin
            cmd.pop_commit = 1'b1;
            state_in       = sfa_pkg::ST_POP_RD;
         end
         sfa_pkg::ST_DONE: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sfa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/sfa_datapath.sv */
// ----------------------------------------------------------------------------
// Stack frame allocator datapath
// Arena registers, frame table memory, used bits and the result registers.
// ----------------------------------------------------------------------------
module sfa_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  sfa_pkg::cmd_type                cmd,
   output sfa_pkg::stat_type               stat,
   input  logic                            csr_wr_en,
   input  logic [sfa_pkg::SIZE_BITS-1:0]   csr_wr_data,
   input  logic                            req_op,
   input  logic [sfa_pkg::SIZE_BITS-1:0]   req_request_bytes,
   input  logic [sfa_pkg::ADDR_BITS-1:0]   req_block_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfa_pkg::ADDR_BITS-1:0]   rsp_granted_address,
   output logic [1:0]                      rsp_status
);

   localparam int IDX = sfa_pkg::FRAME_IDX_BITS;
   localparam int CNT = sfa_pkg::COUNT_BITS;
   localparam int SB  = sfa_pkg::SIZE_BITS;
   localparam int AB  = sfa_pkg::ADDR_BITS;
   localparam int MB  = sfa_pkg::MEM_BITS;
   localparam int TB  = sfa_pkg::TAIL_BITS;

   logic [SB-1:0]  arena_ff;
   logic [SB-1:0]  last_frame_ff;
   logic [CNT-1:0] count_ff;
   logic [CNT-1:0] idx_ff;
   logic [sfa_pkg::MAX_FRAMES-1:0] used_ff;
   logic [SB-1:0]  frame_mem [sfa_pkg::MAX_FRAMES];
   logic [SB-1:0]  rdata_ff;

   sfa_pkg::op_type op_ff;
   logic [SB-1:0]  req_ff;
   logic [AB-1:0]  blk_ff;

   sfa_pkg::status_type pend_status_ff, alloc_status;
   logic [AB-1:0]  pend_addr_ff;
   logic           rsp_valid_ff;
   logic [AB-1:0]  rsp_addr_ff;
   sfa_pkg::status_type rsp_status_ff;

   logic [MB-1:0]  size_up;
   logic [MB-1:0]  size_even;
   logic [MB-1:0]  mem_off;
   logic [TB-1:0]  tail;
   logic           arena_fail;
   logic           table_full;
   logic           push;
   logic [CNT-1:0] count_m1;
   logic [IDX-1:0] top_idx;
   logic [IDX-1:0] rd_addr;
   logic [MB-1:0]  hit_off;

   // allocation sizing: round up to even, block after the last header
   assign size_up    = {1'b0, req_ff} + MB'(1);
   assign size_even  = {size_up[MB-1:1], 1'b0};
   assign mem_off    = {1'b0, last_frame_ff} + MB'(sfa_pkg::HDR_EVEN);
   assign tail       = {1'b0, mem_off} + {1'b0, size_even};
   assign arena_fail = (tail > {2'b00, arena_ff}) || (mem_off > MB'(sfa_pkg::ADDR_MASK));
   assign table_full = count_ff >= CNT'(sfa_pkg::MAX_FRAMES);
   assign push       = cmd.alloc && !arena_fail && !table_full;

   always_comb begin
      if (arena_fail) begin
         alloc_status = sfa_pkg::STATUS_ARENA_FULL;
      end else if (table_full) begin
         alloc_status = sfa_pkg::STATUS_TABLE_FULL;
      end else begin
         alloc_status = sfa_pkg::STATUS_OK;
      end
   end

   assign count_m1 = count_ff - CNT'(1);
   assign top_idx  = count_m1[IDX-1:0];
   assign rd_addr  = (cmd.rd_sel == sfa_pkg::RD_POP) ? top_idx : idx_ff[IDX-1:0];
   assign hit_off  = {1'b0, rdata_ff} + MB'(sfa_pkg::HDR_EVEN);

   assign stat.is_free    = (op_ff == sfa_pkg::OP_FREE);
   assign stat.search_end = (idx_ff >= count_ff);
   assign stat.match      = (hit_off == {{(MB-AB){1'b0}}, blk_ff});
   assign stat.pop_stop   = (count_ff == '0) || used_ff[top_idx];
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // frame table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (push) begin
         frame_mem[count_ff[IDX-1:0]] <= last_frame_ff;
      end
      if (cmd.rd_en) begin
         rdata_ff <= frame_mem[rd_addr];
      end
   end

   // payload capture, pending result and output result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= sfa_pkg::op_type'(req_op);
         req_ff <= req_request_bytes;
         blk_ff <= req_block_address;
      end
      if (cmd.alloc) begin
         pend_status_ff <= alloc_status;
         pend_addr_ff   <= push ? mem_off[AB-1:0] : '0;
      end else if (cmd.pend_ok) begin
         pend_status_ff <= sfa_pkg::STATUS_OK;
         pend_addr_ff   <= '0;
      end else if (cmd.pend_not_found) begin
         pend_status_ff <= sfa_pkg::STATUS_NOT_FOUND;
         pend_addr_ff   <= '0;
      end
      if (cmd.out_load) begin
         rsp_addr_ff   <= pend_addr_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arena_ff      <= SB'(sfa_pkg::ARENA_RESET);
         last_frame_ff <= SB'(sfa_pkg::BASE_OFFSET);
         count_ff      <= '0;
         idx_ff        <= '0;
         used_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            arena_ff <= csr_wr_data;
         end
         if (cmd.capture) begin
            idx_ff <= '0;
         end else if (cmd.idx_next) begin
            idx_ff <= idx_ff + CNT'(1);
         end
         if (push) begin
            used_ff[count_ff[IDX-1:0]] <= 1'b1;
            count_ff                   <= count_ff + CNT'(1);
            last_frame_ff              <= tail[SB-1:0];
         end else if (cmd.pop_commit) begin
            count_ff      <= count_m1;
            last_frame_ff <= rdata_ff;
         end
         if (cmd.mark_unused) begin
            used_ff[idx_ff[IDX-1:0]] <= 1'b0;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT'(sfa_pkg::MAX_FRAMES))
      else $error("frame count beyond table depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT'(sfa_pkg::MAX_FRAMES)))
      else $error("push into a full frame table");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |=> (count_ff == $past(count_m1)))
      else $error("pop did not drop the frame count");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mark_unused |-> (idx_ff < count_ff))
      else $error("free marked a frame outside the table");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before its transfer");

endmodule

/* rtl/core/stack_frame_allocator.sv */
// Allocate: the request is captured in idle, evaluated in the allocate state, and its
// result is loaded from the done state. Free reads then checks each frame from index 0,
// marks the match unused, then pops unused top frames, each a read then a commit step;
// with no match it gives not found. Each read uses the table's single read port. One
// item at a time: the next request can transfer the cycle after the result is loaded.
// Reset: arena size 1048576, last frame at the base offset, no frames, used bits clear.
// ----------------------------------------------------------------------------
// Stack frame allocator
// Arena bump allocator with frame headers and out-of-order free.
// ----------------------------------------------------------------------------
module stack_frame_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sfa_pkg::SIZE_BITS-1:0] csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [sfa_pkg::SIZE_BITS-1:0] req_request_bytes,
   input  logic [sfa_pkg::ADDR_BITS-1:0] req_block_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sfa_pkg::ADDR_BITS-1:0] rsp_granted_address,
   output logic [1:0]                    rsp_status
);

   sfa_pkg::cmd_type  cmd;
   sfa_pkg::stat_type stat;

   sfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfa_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

endmodule

/* tb/sv/sfa_checker.sv */
// ----------------------------------------------------------------------------
// Stack frame allocator checker
// Watches the register port and both channels, predicts each result of the
// allocator from its own copy of the frame table and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module sfa_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sfa_pkg::SIZE_BITS-1:0] csr_wr_data,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  logic [sfa_pkg::SIZE_BITS-1:0] req_request_bytes,
   input  logic [sfa_pkg::ADDR_BITS-1:0] req_block_address,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sfa_pkg::ADDR_BITS-1:0] rsp_granted_address,
   input  logic [1:0]                    rsp_status,
   output int                            pending_results,
   output int                            fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW = sfa_pkg::SIZE_BITS;
   localparam int AW = sfa_pkg::ADDR_BITS;
   localparam int TW = sfa_pkg::TAIL_BITS;

   typedef struct packed {
      logic [AW-1:0]       address;
      sfa_pkg::status_type status;
   } grant_type;

   logic [SW-1:0] arena_size;
   logic [TW-1:0] tail_header;
   int unsigned   frame_depth;
   logic [TW-1:0] frame_header [sfa_pkg::MAX_FRAMES];
   logic          frame_live [sfa_pkg::MAX_FRAMES];
   grant_type     expected_grants [$];

   function automatic grant_type predict_allocation(logic [SW-1:0] bytes);
      logic [TW-1:0] size_even;
      logic [TW-1:0] block_at;
      logic [TW-1:0] new_tail;
      grant_type     grant;
      size_even    = TW'(bytes) + 1'b1;
      size_even[0] = 1'b0;
      block_at     = tail_header + TW'(sfa_pkg::HDR_EVEN);
      new_tail     = block_at + size_even;
      grant.address = '0;
      grant.status  = sfa_pkg::STATUS_OK;
      if (new_tail > TW'(arena_size) || block_at > TW'(sfa_pkg::ADDR_MASK)) begin
         grant.status = sfa_pkg::STATUS_ARENA_FULL;
      end else if (frame_depth >= sfa_pkg::MAX_FRAMES) begin
         grant.status = sfa_pkg::STATUS_TABLE_FULL;
      end else begin
         frame_header[frame_depth] = tail_header;
         frame_live[frame_depth]   = 1'b1;
         frame_depth++;
         tail_header   = new_tail;
         grant.address = block_at[AW-1:0];
      end
      return grant;
   endfunction

   function automatic grant_type predict_release(logic [AW-1:0] block);
      int        hit;
      grant_type grant;
      hit           = -1;
      grant.address = '0;
      grant.status  = sfa_pkg::STATUS_OK;
      for (int i = 0; i < frame_depth; i++) begin
         if (hit < 0 && frame_header[i] + TW'(sfa_pkg::HDR_EVEN) == TW'(block)) begin
            hit = i;
         end
      end
      if (hit < 0) begin
         grant.status = sfa_pkg::STATUS_NOT_FOUND;
      end else begin
         frame_live[hit] = 1'b0;
         // drop every unused frame off the top
         while (frame_depth > 0 && !frame_live[frame_depth-1]) begin
            tail_header = frame_header[frame_depth-1];
            frame_depth--;
         end
      end
      return grant;
   endfunction

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         arena_size  = SW'(sfa_pkg::ARENA_RESET);
         tail_header = TW'(sfa_pkg::BASE_OFFSET);
         frame_depth = 0;
         fail_count  = 0;
         for (int i = 0; i < sfa_pkg::MAX_FRAMES; i++) begin
            frame_live[i] = 1'b0;
         end
         expected_grants.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("result transfer with nothing expected: granted_address 0x%05h status %0d",
                      rsp_granted_address, rsp_status);
               fail_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_granted_address !== want.address) begin
                  $error("granted_address: expected 0x%05h, got 0x%05h",
                         want.address, rsp_granted_address);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d (%s), got %0d",
                         want.status, want.status.name(), rsp_status);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) begin
            arena_size = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            if (sfa_pkg::op_type'(req_op) == sfa_pkg::OP_FREE) begin
               expected_grants.push_back(predict_release(req_block_address));
            end else begin
               expected_grants.push_back(predict_allocation(req_request_bytes));
            end
         end
      end
      pending_results = expected_grants.size();
   end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// Stack frame allocator testbench
// Drives directed and random allocate/free traffic through several arena
// sizes, with random gaps on both channels, and lets the checker judge each
// result.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW      = sfa_pkg::SIZE_BITS;
   localparam int AW      = sfa_pkg::ADDR_BITS;
   localparam int REQ_MAX = sfa_pkg::ARENA_RESET;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_wr_en;
   logic [SW-1:0] csr_wr_data;
   logic          req_valid;
   logic          req_ready;
   logic          req_op;
   logic [SW-1:0] req_request_bytes;
   logic [AW-1:0] req_block_address;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [AW-1:0] rsp_granted_address;
   logic [1:0]    rsp_status;

   int            pending_results;
   int            fail_count;

   bit            idle_enabled = 1'b1;
   int            hold_requests = 0;
   int            alloc_sent = 0;
   int            free_sent = 0;
   int            arena_writes = 0;
   logic [AW-1:0] granted_pool [$];

   stack_frame_allocator dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

   sfa_checker alloc_check (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_request_bytes   (req_request_bytes),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .pending_results     (pending_results),
      .fail_count          (fail_count)
   );

   always #5 clock = ~clock;

   initial begin
      #10ms;
      $display("tb: done, errors");
      $finish;
   end

   // Mostly back to back, now and then a short gap, rarely a long one.
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_enabled || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end else if (roll < 98) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // Remember granted blocks so that most frees name a real frame.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && rsp_status == sfa_pkg::STATUS_OK &&
          rsp_granted_address != '0) begin
         granted_pool.push_back(rsp_granted_address);
         if (granted_pool.size() > 96) begin
            void'(granted_pool.pop_front());
         end
      end
   end

   initial begin
      int stall_left;
      int hold_seen;
      stall_left = 0;
      hold_seen  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen  = hold_requests;
            stall_left = 300;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready  <= 1'b1;
            stall_left = idle_cycles();
         end
      end
   end

   task automatic send_item(sfa_pkg::op_type op, logic [SW-1:0] bytes,
                            logic [AW-1:0] block);
      int gap;
      gap = idle_cycles();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_request_bytes <= bytes;
      req_block_address <= block;
      if (op == sfa_pkg::OP_FREE) begin
         free_sent++;
      end else begin
         alloc_sent++;
      end
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic alloc_item(int unsigned bytes);
      send_item(sfa_pkg::OP_ALLOC, SW'(bytes), AW'($urandom_range(0, sfa_pkg::ADDR_MASK)));
   endtask

   task automatic free_item(int unsigned block);
      send_item(sfa_pkg::OP_FREE, SW'($urandom_range(0, REQ_MAX)), AW'(block));
   endtask

   // Hold the sender until every result is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
   endtask

   task automatic write_arena(int unsigned bytes);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= SW'(bytes);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      arena_writes++;
   endtask

   task automatic free_from_pool();
      int            idx;
      logic [AW-1:0] block;
      if (granted_pool.size() == 0) begin
         alloc_item($urandom_range(0, 16));
      end else begin
         idx   = $urandom_range(0, granted_pool.size() - 1);
         block = granted_pool[idx];
         // keep a few around for double frees
         if ($urandom_range(0, 99) < 85) begin
            granted_pool.delete(idx);
         end
         free_item(32'(block));
      end
   endtask

   task automatic random_item();
      int            roll;
      int            pick;
      logic [AW-1:0] block;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < 45) begin
         if (pick < 88) begin
            alloc_item($urandom_range(0, 64));
         end else if (pick < 97) begin
            alloc_item($urandom_range(0, REQ_MAX));
         end else begin
            alloc_item(REQ_MAX);
         end
      end else if (roll < 82) begin
         free_from_pool();
      end else if (roll < 90 && granted_pool.size() != 0) begin
         block = granted_pool[$urandom_range(0, granted_pool.size() - 1)];
         free_item(pick < 50 ? 32'(block) + 32'd2 : 32'(block) - 32'd2);
      end else begin
         free_item($urandom_range(0, sfa_pkg::ADDR_MASK));
      end
   endtask

   // Overrun the frame table, then unwind it in random order.
   task automatic fill_burst();
      repeat (sfa_pkg::MAX_FRAMES + 6) alloc_item($urandom_range(0, 8));
      repeat (granted_pool.size() + 6) free_from_pool();
   endtask

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_valid         = 1'b0;
      req_op            = sfa_pkg::OP_ALLOC;
      req_request_bytes = '0;
      req_block_address = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: rounding, out-of-order free, double free, unknown frees,
      // arena limits including a block offset past the address range
      alloc_item(0);
      alloc_item(1);
      alloc_item(7);
      free_item(32);
      free_item(32);
      free_item(58);
      free_item(0);
      free_item(sfa_pkg::ADDR_MASK);
      free_item(42);
      free_item(24);
      free_item(24);
      alloc_item(REQ_MAX);
      alloc_item(REQ_MAX - 1);
      alloc_item(REQ_MAX - 24);
      alloc_item(0);
      free_item(24);
      alloc_item(REQ_MAX - 32);
      alloc_item(0);
      free_item(24);
      drain();

      // full frame table, with a long receiver stall while traffic keeps coming
      fill_burst();
      hold_requests++;
      repeat (120) random_item();

      write_arena(0);
      repeat (60) random_item();

      write_arena($urandom_range(40, 600));
      repeat (150) random_item();

      write_arena(REQ_MAX);
      fill_burst();
      repeat (40) random_item();

      // no idling on either side
      write_arena($urandom_range(0, REQ_MAX));
      idle_enabled = 1'b0;
      repeat (100) random_item();

      drain();
      repeat (300) @(negedge clock);

      $display("tb: %0d allocate and %0d free transfers over %0d arena sizes",
               alloc_sent, free_sent, arena_writes + 1);
      $display("tb: covered table overrun, arena overrun, double and unknown frees");
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/sfa_pkg.sv
rtl/core/sfa_ctrl.sv
rtl/core/sfa_datapath.sv
rtl/core/stack_frame_allocator.sv
tb/sv/sfa_checker.sv
tb/sv/tb.sv
